// ===== hw/rtl/cpid_pkg.sv =====
// Shared types and constants for the clamped PID sample step block.
// Used by cpid_front, cpid_back and the top level; depends on nothing else.
`default_nettype none

package cpid_pkg;

  // Default fixed-point format and sample width.
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned SampleBitsDef = 8;

  // Fixed field widths.
  localparam int unsigned RefW      = 8;
  localparam int unsigned GainW     = 32;
  localparam int unsigned DriveW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // Saturation level of the integer part, in sample units.
  localparam int unsigned ClampInt  = 255;

  // Queue depths (powers of two).
  localparam int unsigned MidDepth  = 4;
  localparam int unsigned OutDepth  = 8;

  // Register reset values.
  localparam logic [RefW-1:0]         RefLevelRst = 8'd128;
  localparam logic signed [GainW-1:0] KpGainRst   = 32'sd65536;
  localparam logic signed [GainW-1:0] KiGainRst   = 32'sd819;
  localparam logic signed [GainW-1:0] KdGainRst   = 32'sd0;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_REF_LEVEL    = 2'd0,
    REG_KP_GAIN      = 2'd1,
    REG_KI_STEP_GAIN = 2'd2,
    REG_KD_RATE_GAIN = 2'd3
  } cfg_reg_e;

  // Gain set handed from the register file to the datapath.
  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
  } gains_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpid_fifo.sv =====
// Small first-in first-out queue built from a register array.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module cpid_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + AW'(1);
      end
      count_q <= count_d;
    end
  end

  // Storage holds payload only, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpid_front.sv =====
// Front end: accepts samples, forms the signed error against the setpoint
// and queues it for the datapath. Depends on cpid_pkg and cpid_fifo.
`default_nettype none

module cpid_front #(
  parameter int unsigned SAMPLE_BITS = cpid_pkg::SampleBitsDef,
  localparam int unsigned ErrW       = SAMPLE_BITS + 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic [cpid_pkg::RefW-1:0]     ref_level_i,
  output logic signed [ErrW-1:0]             err_o,
  output logic                               err_valid_o,
  input  wire logic                          err_pop_i
);

  logic [ErrW-1:0] ref_ext, smp_ext, err_new, err_raw;
  logic            q_empty;

  // Error is setpoint minus sample, one bit wider to carry the sign.
  assign ref_ext = ErrW'(ref_level_i);
  assign smp_ext = ErrW'(sample_i);
  assign err_new = ref_ext - smp_ext;

  // Queue between front and back lets each side stall on its own.
  cpid_fifo #(
    .WIDTH(ErrW),
    .DEPTH(cpid_pkg::MidDepth)
  ) u_err_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(err_new),
    .full_o (full),
    .pop_i  (err_pop_i),
    .rdata_o(err_raw),
    .empty_o(q_empty)
  );

  assign err_o       = $signed(err_raw);
  assign err_valid_o = !q_empty;

endmodule

`default_nettype wire

// ===== hw/rtl/cpid_back.sv =====
// Back end: gain products, clamped integral and derivative update, output
// sum and saturation, then the result queue. Depends on cpid_pkg, cpid_fifo.
`default_nettype none

module cpid_back #(
  parameter int unsigned FRAC_BITS   = cpid_pkg::FracBitsDef,
  parameter int unsigned SAMPLE_BITS = cpid_pkg::SampleBitsDef,
  localparam int unsigned ErrW       = SAMPLE_BITS + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cpid_pkg::gains_t            gains_i,
  input  wire logic signed [ErrW-1:0]      err_i,
  input  wire logic                        err_valid_i,
  output logic                             err_pop_o,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [cpid_pkg::DriveW-1:0]      drive_o
);

  // State word holds +/-255 in the fixed-point format with headroom.
  localparam int unsigned StW   = FRAC_BITS + 10;
  localparam int unsigned ProdW = ErrW + cpid_pkg::GainW;
  localparam int unsigned AccW  = ProdW + 1;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned StSW  = StW + 1;
  localparam int unsigned CrW   = $clog2(cpid_pkg::OutDepth + 1);

  localparam longint Lim    = longint'(cpid_pkg::ClampInt) << FRAC_BITS;
  localparam longint SatTop = longint'(cpid_pkg::ClampInt + 1) << FRAC_BITS;

  localparam logic signed [AccW-1:0] LimAccP = AccW'(Lim);
  localparam logic signed [AccW-1:0] LimAccN = AccW'(-Lim);
  localparam logic signed [ProdW-1:0] LimPrP = ProdW'(Lim);
  localparam logic signed [ProdW-1:0] LimPrN = ProdW'(-Lim);
  localparam logic signed [StSW-1:0] LimStP  = StSW'(Lim);
  localparam logic signed [StSW-1:0] LimStN  = StSW'(-Lim);
  localparam logic signed [StW-1:0]  LimP    = StW'(Lim);
  localparam logic signed [StW-1:0]  LimN    = StW'(-Lim);
  localparam logic signed [SumW-1:0] SatSum  = SumW'(SatTop);

  // Credit count: items in the pipeline plus items in the result queue.
  logic [CrW-1:0] reserved_q, reserved_d;
  logic           issue, out_pop;

  assign issue     = err_valid_i && (reserved_q < CrW'(cpid_pkg::OutDepth));
  assign err_pop_o = issue;
  assign out_pop   = pop && !empty;

  always_comb begin
    reserved_d = reserved_q;
    if (issue && !out_pop) begin
      reserved_d = reserved_q + CrW'(1);
    end else if (out_pop && !issue) begin
      reserved_d = reserved_q - CrW'(1);
    end
  end

  // Stage valids and state registers.
  logic v1_q, v2_q, v3_q;
  logic signed [StW-1:0] iprev_q, iprev_d, dprev_q, dprev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      iprev_q    <= '0;
      dprev_q    <= '0;
    end else begin
      reserved_q <= reserved_d;
      v1_q       <= issue;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      iprev_q    <= iprev_d;
      dprev_q    <= dprev_d;
    end
  end

  // Stage 1: the three gain products.
  logic signed [ProdW-1:0] pkp1_q, pki1_q, pkd1_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pkp1_q <= err_i * gains_i.kp;
      pki1_q <= err_i * gains_i.ki;
      pkd1_q <= err_i * gains_i.kd;
    end
  end

  // Stage 2: new integral and derivative, clamped; state updates here.
  logic signed [AccW-1:0] iacc;
  logic signed [StW-1:0]  ival, d1val;

  always_comb begin
    iacc = AccW'(pki1_q) + AccW'(iprev_q);
    if (iacc > LimAccP) begin
      ival = LimP;
    end else if (iacc < LimAccN) begin
      ival = LimN;
    end else begin
      ival = StW'(iacc);
    end
    if (pkd1_q > LimPrP) begin
      d1val = LimP;
    end else if (pkd1_q < LimPrN) begin
      d1val = LimN;
    end else begin
      d1val = StW'(pkd1_q);
    end
    iprev_d = iprev_q;
    dprev_d = dprev_q;
    if (v1_q) begin
      iprev_d = ival;
      dprev_d = d1val;
    end
  end

  logic signed [ProdW-1:0] pkp2_q;
  logic signed [StW-1:0]   i2_q, iold2_q, d12_q, dold2_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      pkp2_q  <= pkp1_q;
      i2_q    <= ival;
      iold2_q <= iprev_q;
      d12_q   <= d1val;
      dold2_q <= dprev_q;
    end
  end

  // Stage 3: trapezoid integral term and derivative difference, clamped.
  logic signed [StSW-1:0] isum, ddiff;
  logic signed [StW-1:0]  iterm, dterm;

  always_comb begin
    isum  = StSW'(i2_q) + StSW'(iold2_q);
    ddiff = StSW'(d12_q) - StSW'(dold2_q);
    if (isum > LimStP) begin
      iterm = LimP;
    end else if (isum < LimStN) begin
      iterm = LimN;
    end else begin
      iterm = StW'(isum);
    end
    if (ddiff > LimStP) begin
      dterm = LimP;
    end else if (ddiff < LimStN) begin
      dterm = LimN;
    end else begin
      dterm = StW'(ddiff);
    end
  end

  logic signed [ProdW-1:0] pkp3_q;
  logic signed [StW-1:0]   iterm3_q, dterm3_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      pkp3_q   <= pkp2_q;
      iterm3_q <= iterm;
      dterm3_q <= dterm;
    end
  end

  // Stage 4: full sum, then saturate to the unsigned drive range.
  logic signed [SumW-1:0]       sum;
  logic [cpid_pkg::DriveW-1:0]  drive_new;

  always_comb begin
    sum = SumW'(pkp3_q) + SumW'(iterm3_q) + SumW'(dterm3_q);
    if (sum <= SumW'(0)) begin
      drive_new = '0;
    end else if (sum >= SatSum) begin
      drive_new = cpid_pkg::DriveW'(cpid_pkg::ClampInt);
    end else begin
      drive_new = sum[FRAC_BITS +: cpid_pkg::DriveW];
    end
  end

  // Result queue; credits guarantee it never overflows.
  logic out_full;
  logic unused_full;

  assign unused_full = out_full;

  cpid_fifo #(
    .WIDTH(cpid_pkg::DriveW),
    .DEPTH(cpid_pkg::OutDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (v3_q),
    .wdata_i(drive_new),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(drive_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/clamped_pid_sample_step.sv =====
// Top level of the clamped PID sample step: register file, front end
// and back end. Depends on cpid_pkg, cpid_front and cpid_back.
`default_nettype none

// One measured sample in, one 8-bit drive value out, in order. The block
// sustains one item per clock while results are popped and the queues do not
// fill: the front end forms the error and queues it, and the back end runs
// a four-stage pipeline (gain products, integral and derivative update,
// clamped terms, sum and saturation). The state update closes in a single
// stage, so consecutive samples never wait on each other. Results wait in
// an eight-entry queue, and the back end stops drawing errors only when
// that queue and the pipeline together hold eight items.
// Registers are written over the cfg channel, which is always ready; write
// them only while no item is in flight. Indexes: 0 setpoint, 1 kp,
// 2 ki*T/2, 3 kd/T, gains in signed fixed point with FRAC_BITS fraction bits.
module clamped_pid_sample_step #(
  parameter int unsigned FRAC_BITS   = cpid_pkg::FracBitsDef,
  parameter int unsigned SAMPLE_BITS = cpid_pkg::SampleBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [cpid_pkg::DriveW-1:0]          drive_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [cpid_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [cpid_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned ErrW = SAMPLE_BITS + 1;

  logic [cpid_pkg::RefW-1:0] ref_level_q;
  cpid_pkg::gains_t          gains_q;
  logic                      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_level_q <= cpid_pkg::RefLevelRst;
      gains_q.kp  <= cpid_pkg::KpGainRst;
      gains_q.ki  <= cpid_pkg::KiGainRst;
      gains_q.kd  <= cpid_pkg::KdGainRst;
    end else if (cfg_we) begin
      case (cpid_pkg::cfg_reg_e'(cfg_index_i))
        cpid_pkg::REG_REF_LEVEL: begin
          ref_level_q <= cfg_data_i[cpid_pkg::RefW-1:0];
        end
        cpid_pkg::REG_KP_GAIN: begin
          gains_q.kp <= $signed(cfg_data_i);
        end
        cpid_pkg::REG_KI_STEP_GAIN: begin
          gains_q.ki <= $signed(cfg_data_i);
        end
        cpid_pkg::REG_KD_RATE_GAIN: begin
          gains_q.kd <= $signed(cfg_data_i);
        end
        default: begin
        end
      endcase
    end
  end

  logic signed [ErrW-1:0] err;
  logic                   err_valid;
  logic                   err_pop;

  // Front end: error formation and the decoupling queue.
  cpid_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (sample_i),
    .ref_level_i(ref_level_q),
    .err_o      (err),
    .err_valid_o(err_valid),
    .err_pop_i  (err_pop)
  );

  // Back end: controller arithmetic and the result queue.
  cpid_back #(
    .FRAC_BITS  (FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gains_i    (gains_q),
    .err_i      (err),
    .err_valid_i(err_valid),
    .err_pop_o  (err_pop),
    .pop        (pop),
    .empty      (empty),
    .drive_o    (drive_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_clamped_pid_sample_step.sv =====
// Self-checking testbench for clamped_pid_sample_step: a directed table, then random phases.
// Drive values are predicted in-bench and compared in order; depends on cpid_pkg and the RTL.
module tb_clamped_pid_sample_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frac        = cpid_pkg::FracBitsDef;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned PhaseItems  = 153;
  localparam int unsigned LongHold    = 100;
  localparam int unsigned DirRows     = 31;

  // One row of the directed table: a register write or a sample item.
  typedef struct packed {
    logic              is_cfg;
    cpid_pkg::cfg_reg_e idx;
    logic [31:0]       data;
    logic [7:0]        samp;
    logic              typed;
    logic [7:0]        drv;
  } dir_row_t;

  typedef struct {
    int unsigned       seq;
    logic [7:0]        drive;
  } drive_exp_t;

  logic                          clk;
  logic                          rst_n;
  logic                          push;
  logic                          full;
  logic [7:0]                    sample;
  logic                          empty;
  logic                          pop;
  logic [cpid_pkg::DriveW-1:0]   drive;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cpid_pkg::CfgIdxW-1:0]  cfg_index;
  logic [cpid_pkg::CfgDataW-1:0] cfg_data;

  // Expected drive for the item on the input side, when the table gives it.
  logic                typed_now;
  logic [7:0]          typed_drive;

  bit                  hold_req = 1'b0;
  bit                  rx_eager = 1'b0;
  int unsigned         fails    = 0;
  int unsigned         item_seq = 0;

  // Predictor copy of the registers and the controller state.
  logic [7:0]          ref_lvl;
  longint              kp_q;
  longint              ki_q;
  longint              kd_q;
  longint              integ_q;
  longint              deriv_q;

  drive_exp_t          drive_exp_q[$];

  // Directed items: after reset, gain extremes and saturation at both ends.
  dir_row_t dir_tab [DirRows] = '{
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd128, 1'b1, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd255, 1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_KP_GAIN,      32'h7FFFFFFF, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b1, 8'd255},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd255, 1'b1, 8'd0},
    '{1'b1, cpid_pkg::REG_KP_GAIN,      32'h80000000, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b1, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd255, 1'b1, 8'd255},
    '{1'b1, cpid_pkg::REG_KP_GAIN,      32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_KI_STEP_GAIN, 32'h7FFFFFFF, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b1, 8'd255},
    '{1'b1, cpid_pkg::REG_KI_STEP_GAIN, 32'h80000000, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b1, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b1, 8'd0},
    '{1'b1, cpid_pkg::REG_KI_STEP_GAIN, 32'h1,        8'd0,   1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_KD_RATE_GAIN, 32'h7FFFFFFF, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd255, 1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_KD_RATE_GAIN, 32'h80000000, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_KD_RATE_GAIN, 32'hFFFFFFFF, 8'd0,   1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_REF_LEVEL,    32'd255,      8'd0,   1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_KP_GAIN,      32'h00008000, 8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd255, 1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd254, 1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b1, cpid_pkg::REG_REF_LEVEL,    32'd0,        8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd0,   1'b0, 8'd0},
    '{1'b0, cpid_pkg::REG_REF_LEVEL,    32'h0,        8'd255, 1'b0, 8'd0}
  };

  clamped_pid_sample_step u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .sample_i    (sample),
    .empty       (empty),
    .pop         (pop),
    .drive_o     (drive),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    fails++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Computes the drive for one sample and advances the integral and derivative state.
  function automatic logic [7:0] pid_step_drive(input logic [7:0] s);
    longint lim;
    longint err;
    longint i_new;
    longint i_sum;
    longint d_new;
    longint d_diff;
    longint total;
    lim    = longint'(cpid_pkg::ClampInt) <<< Frac;
    err    = longint'(ref_lvl) - longint'(s);
    i_new  = clamp_sym(integ_q + err * ki_q, lim);
    i_sum  = clamp_sym(i_new + integ_q, lim);
    d_new  = clamp_sym(err * kd_q, lim);
    d_diff = clamp_sym(d_new - deriv_q, lim);
    total  = err * kp_q + i_sum + d_diff;
    integ_q = i_new;
    deriv_q = d_new;
    if (total <= 0) return 8'd0;
    if ((total >>> Frac) > 255) return 8'd255;
    return 8'(total >>> Frac);
  endfunction

  // Tracks register writes, predicts each accepted sample and checks each popped drive.
  always @(posedge clk or negedge rst_n) begin : monitor
    drive_exp_t exp_item;
    logic [7:0] predicted;
    if (!rst_n) begin
      ref_lvl = cpid_pkg::RefLevelRst;
      kp_q    = longint'(cpid_pkg::KpGainRst);
      ki_q    = longint'(cpid_pkg::KiGainRst);
      kd_q    = longint'(cpid_pkg::KdGainRst);
      integ_q = 0;
      deriv_q = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cpid_pkg::cfg_reg_e'(cfg_index))
          cpid_pkg::REG_REF_LEVEL:    ref_lvl = cfg_data[7:0];
          cpid_pkg::REG_KP_GAIN:      kp_q = longint'($signed(cfg_data));
          cpid_pkg::REG_KI_STEP_GAIN: ki_q = longint'($signed(cfg_data));
          cpid_pkg::REG_KD_RATE_GAIN: kd_q = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (push && !full) begin
        predicted = pid_step_drive(sample);
        if (typed_now) predicted = typed_drive;
        exp_item.seq   = item_seq;
        exp_item.drive = predicted;
        drive_exp_q.push_back(exp_item);
        item_seq++;
      end
      if (pop && !empty) begin
        if (drive_exp_q.size() == 0) begin
          report_mismatch($sformatf("drive %0d popped with no sample outstanding", drive));
        end else begin
          exp_item = drive_exp_q.pop_front();
          if (drive !== exp_item.drive)
            report_mismatch($sformatf("item %0d: drive %0d, expected %0d",
                                      exp_item.seq, drive, exp_item.drive));
        end
      end
    end
  end

  // Result side: mostly short stalls, a few long ones, and a very long hold on each request.
  initial begin : receiver
    int unsigned stall;
    int unsigned r;
    stall = 0;
    pop   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        stall = LongHold - 1;
      end else if (rx_eager) begin
        pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          pop <= 1'b1;
        end else if (r < 92) begin
          pop <= 1'b0;
          stall = $urandom_range(0, 2);
        end else begin
          pop <= 1'b0;
          stall = $urandom_range(4, 29);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Samples cluster around the setpoint so the sum often lands inside 0..255.
  function automatic logic [7:0] pick_sample();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(0, 255));
    if (r < 85) begin
      v = int'(ref_lvl) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    end
    if (r < 92) return 8'd0;
    if (r < 99) return 8'd255;
    return ref_lvl;
  endfunction

  // Gains: mostly near unity or tiny, sometimes any 32-bit value or an extreme.
  function automatic logic [31:0] rand_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom;
    if (r < 7) return $urandom_range(0, 196608) - 32'd98304;
    if (r < 9) return $urandom_range(0, 4000) - 32'd2000;
    case ($urandom_range(0, 4))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'h0;
      3:       return 32'h1;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  // Offers one sample after an optional gap; returns at the falling edge after acceptance.
  task automatic send(input logic [7:0] s, input logic typed, input logic [7:0] d,
                      input int unsigned gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    sample      <= s;
    typed_now   <= typed;
    typed_drive <= d;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected drive is out and the pipeline is quiet.
  task automatic drain();
    push <= 1'b0;
    while (drive_exp_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Holds the write channel valid until the write is taken; the caller lowers it.
  task automatic write_reg(input cpid_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Register settings per phase: all maxima, all minima, reset values, then random.
  task automatic configure_phase(input int unsigned ph);
    case (ph)
      0: begin
        write_reg(cpid_pkg::REG_REF_LEVEL, 32'd255);
        write_reg(cpid_pkg::REG_KP_GAIN, 32'h7FFFFFFF);
        write_reg(cpid_pkg::REG_KI_STEP_GAIN, 32'h7FFFFFFF);
        write_reg(cpid_pkg::REG_KD_RATE_GAIN, 32'h7FFFFFFF);
      end
      1: begin
        write_reg(cpid_pkg::REG_REF_LEVEL, 32'd0);
        write_reg(cpid_pkg::REG_KP_GAIN, 32'h80000000);
        write_reg(cpid_pkg::REG_KI_STEP_GAIN, 32'h80000000);
        write_reg(cpid_pkg::REG_KD_RATE_GAIN, 32'h80000000);
      end
      2: begin
        write_reg(cpid_pkg::REG_REF_LEVEL, 32'(cpid_pkg::RefLevelRst));
        write_reg(cpid_pkg::REG_KP_GAIN, 32'(cpid_pkg::KpGainRst));
        write_reg(cpid_pkg::REG_KI_STEP_GAIN, 32'(cpid_pkg::KiGainRst));
        write_reg(cpid_pkg::REG_KD_RATE_GAIN, 32'(cpid_pkg::KdGainRst));
      end
      default: begin
        if ($urandom_range(0, 9) < 8) write_reg(cpid_pkg::REG_REF_LEVEL, $urandom);
        if ($urandom_range(0, 9) < 7) write_reg(cpid_pkg::REG_KP_GAIN, rand_gain());
        if ($urandom_range(0, 9) < 7) write_reg(cpid_pkg::REG_KI_STEP_GAIN, rand_gain());
        if ($urandom_range(0, 9) < 7) write_reg(cpid_pkg::REG_KD_RATE_GAIN, rand_gain());
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: reset, the directed table, then random phases between idle register updates.
  initial begin : stimulus
    bit          writing;
    bit          tx_burst;
    int unsigned i;
    int unsigned ph;
    int unsigned k;
    writing     = 1'b0;
    rst_n       = 1'b0;
    push        = 1'b0;
    sample      = '0;
    typed_now   = 1'b0;
    typed_drive = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DirRows; i++) begin
      if (dir_tab[i].is_cfg) begin
        if (!writing) begin
          drain();
          writing = 1'b1;
        end
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        if (writing) begin
          cfg_valid <= 1'b0;
          writing = 1'b0;
        end
        send(dir_tab[i].samp, dir_tab[i].typed, dir_tab[i].drv, pick_gap());
      end
    end

    for (ph = 0; ph < PhaseCount; ph++) begin
      drain();
      configure_phase(ph);
      // Result-side mode changes land after a rising edge, away from the receiver's edge.
      @(posedge clk);
      rx_eager = ($urandom_range(0, 3) == 0);
      tx_burst = (ph % 4 == 3) || ($urandom_range(0, 4) == 0);
      if (ph == 3 || ph == 9) begin
        rx_eager = 1'b0;
        hold_req = 1'b1;
      end
      @(negedge clk);
      for (k = 0; k < PhaseItems; k++) begin
        // Once mid-phase the sender waits for every result before going on.
        if (ph == 6 && k == PhaseItems / 2) drain();
        send(pick_sample(), 1'b0, 8'd0, tx_burst ? 0 : pick_gap());
      end
    end

    drain();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
